FILE: hw/rtl/p2r_pkg.sv
package p2r_pkg;

  // Width of the internal angle accumulator; pi maps to 2^31.
  localparam int unsigned ANGLE_W = 33;
  // Number of stored arctangent entries; more steps than this bring nothing.
  localparam int unsigned TABLE_LEN = 24;
  // Fraction bits carried below the result's least significant bit.
  localparam int unsigned GUARD_BITS = 16;

  typedef logic signed [ANGLE_W-1:0] angle_t;

  // CORDIC gain compensation, about 0.60725293500888 in Q1.30.
  localparam logic signed [30:0] GAIN_Q30 = 31'sd652032874;

  // atan(2^-i) scaled so that pi is 2^31, rounded.
  localparam angle_t ATAN_TABLE [TABLE_LEN] = '{
    33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756,
    33'sd42667331,  33'sd21354465,  33'sd10679838,  33'sd5340245,
    33'sd2670163,   33'sd1335087,   33'sd667544,    33'sd333772,
    33'sd166886,    33'sd83443,     33'sd41722,     33'sd20861,
    33'sd10430,     33'sd5215,      33'sd2608,      33'sd1304,
    33'sd652,       33'sd326,       33'sd163,       33'sd81
  };

endpackage

FILE: hw/rtl/p2r_stage.sv
module p2r_stage
  import p2r_pkg::*;
#(
  parameter int unsigned XW    = 34,
  parameter int unsigned SHIFT = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  angle_t               z_i,
  output logic                 valid_o,
  output logic signed [XW-1:0] x_o,
  output logic signed [XW-1:0] y_o,
  output angle_t               z_o
);

  logic signed [XW-1:0] dx, dy;
  logic signed [XW-1:0] x_d, y_d, x_q, y_q;
  angle_t               z_d, z_q;
  logic                 valid_q;

  // Rotate towards zero residual angle; the shifts are floor shifts.
  always_comb begin
    dx = y_i >>> SHIFT;
    dy = x_i >>> SHIFT;
    if (!z_i[ANGLE_W-1]) begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - ATAN_TABLE[SHIFT];
    end else begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + ATAN_TABLE[SHIFT];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;

endmodule

FILE: hw/rtl/polar_to_rectangular_top.sv
// Polar to rectangular conversion by a pipelined CORDIC in rotation mode. Each slave word
// carries a signed Q1.(DATA_WIDTH-1) magnitude and a 16-bit binary angle (pi is 32768);
// each master word carries magnitude*cos and magnitude*sin, rounded and saturated to the
// same Q format. One word is taken every cycle while the pipeline is not held, and the result
// passes through these register stages in order: gain multiply with quadrant fold, start
// vector rounding, one register stage per CORDIC step (NSTEPS steps, where NSTEPS is
// ITERATIONS capped at 24), output rounding. When the master side stalls with a result
// waiting, the whole pipeline holds and the slave side is not ready until it moves again.
module polar_to_rectangular_top
  import p2r_pkg::*;
#(
  parameter int unsigned ITERATIONS = 16,
  parameter int unsigned DATA_WIDTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  // magnitude [DATA_WIDTH-1:0], angle [DATA_WIDTH+15:DATA_WIDTH], zero padding
  input  logic [((DATA_WIDTH+16+7)/8)*8-1:0]       s_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  // real_part [DATA_WIDTH-1:0], imag_part [2*DATA_WIDTH-1:DATA_WIDTH], zero padding
  output logic [((2*DATA_WIDTH+7)/8)*8-1:0]        m_axis_tdata
);

  localparam int unsigned NSTEPS = (ITERATIONS > TABLE_LEN) ? TABLE_LEN : ITERATIONS;
  localparam int unsigned PW     = DATA_WIDTH + 31;
  localparam int unsigned XW     = DATA_WIDTH + 18;
  localparam int unsigned RW     = XW - GUARD_BITS + 1;
  localparam int unsigned OUT_W  = ((2*DATA_WIDTH+7)/8)*8;
  localparam logic signed [RW-1:0] SAT_HI = RW'((64'sd1 <<< (DATA_WIDTH-1)) - 64'sd1);
  localparam logic signed [RW-1:0] SAT_LO = -SAT_HI - RW'(1);

  logic en;

  // Stage A: gain multiply and quadrant fold.
  logic signed [DATA_WIDTH-1:0] mag;
  logic signed [15:0]           ang;
  logic signed [16:0]           fold_ang_d, fold_ang_q;
  logic                         fold_neg_d, fold_neg_q;
  logic signed [PW-1:0]         prod_d, prod_q;
  logic                         a_valid_q;

  // Stage B: rounded start vector.
  logic signed [PW-1:0]         prod_rnd;
  logic signed [PW-15:0]        x_start;
  logic signed [XW-1:0]         x_b_d, x_b_q;
  angle_t                       z_b_d, z_b_q;
  logic                         b_valid_q;

  logic signed [XW-1:0]         x_pipe [NSTEPS+1];
  logic signed [XW-1:0]         y_pipe [NSTEPS+1];
  angle_t                       z_pipe [NSTEPS+1];
  logic [NSTEPS:0]              v_pipe;

  logic [DATA_WIDTH-1:0]        real_d, real_q, imag_d, imag_q;
  logic                         out_valid_q;
  logic [OUT_W-1:0]             out_data;

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  assign mag = s_axis_tdata[DATA_WIDTH-1:0];
  assign ang = s_axis_tdata[DATA_WIDTH+15:DATA_WIDTH];

  // Angles beyond a quarter turn are brought back by half a turn, flipping the vector.
  always_comb begin
    fold_ang_d = {ang[15], ang};
    fold_neg_d = 1'b0;
    if (ang > 16'sd16384) begin
      fold_ang_d = {ang[15], ang} - 17'sd32768;
      fold_neg_d = 1'b1;
    end else if (ang < -16'sd16384) begin
      fold_ang_d = {ang[15], ang} + 17'sd32768;
      fold_neg_d = 1'b1;
    end
    prod_d = mag * GAIN_Q30;
  end

  always_comb begin
    prod_rnd = prod_q + PW'(1 << (29 - GUARD_BITS));
    x_start  = prod_rnd[PW-1:30-GUARD_BITS];
    x_b_d    = fold_neg_q ? -XW'(x_start) : XW'(x_start);
    z_b_d    = {fold_ang_q, 16'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q   <= s_axis_tvalid;
      b_valid_q   <= a_valid_q;
      out_valid_q <= v_pipe[NSTEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q     <= prod_d;
      fold_ang_q <= fold_ang_d;
      fold_neg_q <= fold_neg_d;
      x_b_q      <= x_b_d;
      z_b_q      <= z_b_d;
      real_q     <= real_d;
      imag_q     <= imag_d;
    end
  end

  assign v_pipe[0] = b_valid_q;
  assign x_pipe[0] = x_b_q;
  assign y_pipe[0] = '0;
  assign z_pipe[0] = z_b_q;

  for (genvar i = 0; i < NSTEPS; i++) begin : g_step
    p2r_stage #(
      .XW    (XW),
      .SHIFT (i)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (v_pipe[i]),
      .x_i     (x_pipe[i]),
      .y_i     (y_pipe[i]),
      .z_i     (z_pipe[i]),
      .valid_o (v_pipe[i+1]),
      .x_o     (x_pipe[i+1]),
      .y_o     (y_pipe[i+1]),
      .z_o     (z_pipe[i+1])
    );
  end

  // Round half up at the guard bits, then clamp to the output range.
  function automatic logic [DATA_WIDTH-1:0] round_sat(input logic signed [XW-1:0] v);
    logic signed [XW:0]   s;
    logic signed [RW-1:0] r;
    s = {v[XW-1], v} + (XW+1)'(1 << (GUARD_BITS - 1));
    r = s[XW:GUARD_BITS];
    if (r > SAT_HI) begin
      r = SAT_HI;
    end else if (r < SAT_LO) begin
      r = SAT_LO;
    end
    return r[DATA_WIDTH-1:0];
  endfunction

  always_comb begin
    real_d = round_sat(x_pipe[NSTEPS]);
    imag_d = round_sat(y_pipe[NSTEPS]);
  end

  always_comb begin
    out_data                          = '0;
    out_data[DATA_WIDTH-1:0]          = real_q;
    out_data[2*DATA_WIDTH-1:DATA_WIDTH] = imag_q;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data;

endmodule

FILE: hw/rtl/p2r_checker.sv
module p2r_checker #(
  parameter int unsigned DATA_WIDTH = 16
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tready,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [((2*DATA_WIDTH+7)/8)*8-1:0]  m_axis_tdata
);

  // A result word waiting on the master side stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // The pipeline takes a new word whenever its output stage can move.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("slave ready does not follow the output stage");

  // Nothing leaves the pipeline in the cycle after it has been held in reset.
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result word offered during reset");

endmodule

bind polar_to_rectangular_top p2r_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_p2r_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: verif/polar_to_rectangular_top_tb.sv
`timescale 1ns / 1ps

module polar_to_rectangular_top_tb;

  localparam int unsigned ITERATIONS  = 16;
  localparam int unsigned DATA_WIDTH  = 16;
  localparam int unsigned PIPE_DEPTH  = ITERATIONS + 3;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned GAP_PERCENT = 7;
  localparam int unsigned RANDOM_WORDS = 1400;
  // Neither side leaves gaps inside this window of cycles.
  localparam int unsigned STEADY_FROM = 600;
  localparam int unsigned STEADY_TO   = 900;

  localparam longint GAIN_Q30 = 64'sd652032874;

  // Arctangent of 2^-i with pi scaled to 2^31, rounded.
  localparam longint ARC_STEP [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  typedef struct packed {
    logic signed [15:0] angle;
    logic signed [15:0] magnitude;
  } polar_word_t;

  typedef struct packed {
    logic signed [15:0] imag_part;
    logic signed [15:0] real_part;
  } cart_word_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  polar_word_t polar_q [$];
  cart_word_t  cart_q [$];
  polar_word_t next_polar;
  cart_word_t  got_cart;
  cart_word_t  want_cart;
  int unsigned cycle_count    = 0;
  int unsigned mismatch_count = 0;
  logic        gaps_on;

  polar_to_rectangular_top #(
    .ITERATIONS(ITERATIONS),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  assign gaps_on = !(cycle_count >= STEADY_FROM && cycle_count < STEADY_TO);

  function automatic logic signed [15:0] round_saturate(longint v);
    longint r;
    r = (v + 64'sd32768) >>> 16;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic cart_word_t rotate_polar(polar_word_t w);
    longint     x;
    longint     y;
    longint     z;
    longint     dx;
    longint     dy;
    cart_word_t r;
    x = (longint'(w.magnitude) * GAIN_Q30 + 64'sd8192) >>> 14;
    y = 0;
    z = longint'(w.angle) * 64'sd65536;
    // Fold the outer quadrants onto the inner half plane by turning through pi.
    if (z > (64'sd1 <<< 30)) begin
      z = z - (64'sd1 <<< 31);
      x = -x;
    end else if (z < -(64'sd1 <<< 30)) begin
      z = z + (64'sd1 <<< 31);
      x = -x;
    end
    for (int i = 0; i < ITERATIONS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ARC_STEP[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ARC_STEP[i];
      end
    end
    r.real_part = round_saturate(x);
    r.imag_part = round_saturate(y);
    return r;
  endfunction

  task automatic queue_polar(logic signed [15:0] mag, logic signed [15:0] ang);
    polar_word_t w;
    w.magnitude = mag;
    w.angle     = ang;
    polar_q.push_back(w);
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Driver: a word is predicted at the edge where it is taken.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        cart_q.push_back(rotate_polar(polar_word_t'(s_axis_tdata)));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (polar_q.size() > 0 && !(gaps_on && $urandom_range(99) < GAP_PERCENT)) begin
          next_polar = polar_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= next_polar;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: every result word is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_cart = m_axis_tdata;
        if (cart_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("unexpected word: real %0d imag %0d",
                     got_cart.real_part, got_cart.imag_part);
          end
        end else begin
          want_cart = cart_q.pop_front();
          if (got_cart.real_part !== want_cart.real_part ||
              got_cart.imag_part !== want_cart.imag_part) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("wrong word: expected real %0d imag %0d, got real %0d imag %0d",
                       want_cart.real_part, want_cart.imag_part,
                       got_cart.real_part, got_cart.imag_part);
            end
          end
        end
      end
      m_axis_tready <= !(gaps_on && $urandom_range(99) < GAP_PERCENT);
    end
  end

  initial begin
    int unsigned pick;
    int          base;
    logic signed [15:0] mag;
    logic signed [15:0] ang;

    // Extremes, the fold boundaries, and the two awkward cases: a full-scale
    // negative radius at angle zero, and an angle of exactly minus pi.
    queue_polar(16'sd32767, 16'sd0);
    queue_polar(-16'sd32768, 16'sd0);
    queue_polar(16'sd0, 16'sd0);
    queue_polar(16'sd1, 16'sd0);
    queue_polar(-16'sd1, 16'sd0);
    queue_polar(16'sd32767, -16'sd32768);
    queue_polar(-16'sd32768, -16'sd32768);
    queue_polar(16'sd32767, 16'sd32767);
    queue_polar(16'sd32767, 16'sd16384);
    queue_polar(16'sd32767, -16'sd16384);
    queue_polar(16'sd32767, 16'sd16385);
    queue_polar(-16'sd32768, -16'sd16385);
    queue_polar(16'sd32767, 16'sd8192);
    queue_polar(-16'sd32768, 16'sd24576);
    queue_polar(16'sd12345, -16'sd8192);
    queue_polar(16'sd32767, 16'sd1);
    queue_polar(-16'sd32768, -16'sd1);
    queue_polar(16'sd16384, -16'sd32767);
    queue_polar(-16'sd32768, 16'sd16384);
    queue_polar(16'sd21000, -16'sd24576);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      pick = $urandom_range(99);
      mag  = 16'($urandom);
      ang  = 16'($urandom);
      if (pick >= 65 && pick < 82) begin
        // Close to a quadrant edge, where the fold and the first step decide.
        base = (int'($urandom_range(3)) - 2) * 16384;
        ang  = 16'(base + int'($urandom_range(16)) - 8);
      end else if (pick >= 82) begin
        // Full-scale radius so that saturation is reached near the axes.
        mag = $urandom_range(1) ? 16'sd32767 : -16'sd32768;
        if ($urandom_range(1)) begin
          ang = 16'((int'($urandom_range(3)) - 2) * 16384 + int'($urandom_range(4)) - 2);
        end
      end
      queue_polar(mag, ang);
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(negedge clk_i);
    while (polar_q.size() != 0 || s_axis_tvalid) @(negedge clk_i);
    while (cart_q.size() != 0) @(negedge clk_i);
    repeat (PIPE_DEPTH + 8) @(negedge clk_i);

    if (mismatch_count == 0 && cart_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/p2r_pkg.sv
hw/rtl/p2r_stage.sv
hw/rtl/polar_to_rectangular_top.sv
hw/rtl/p2r_checker.sv
verif/polar_to_rectangular_top_tb.sv
